/* rtl/nfcs_pkg.sv */
// Package for the NOR flash command sequencer: action and result codes,
// command words, unlock offsets and the burst descriptor types.
// No dependencies.
`default_nettype none

package nfcs_pkg;

  typedef enum logic [1:0] {
    ACT_RESET   = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_STATUS  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DONE  = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  // Address offset selector of one bus operation
  typedef enum logic [1:0] {
    ASEL_ZERO    = 2'd0,
    ASEL_UNLOCK1 = 2'd1,
    ASEL_UNLOCK2 = 2'd2,
    ASEL_TARGET  = 2'd3
  } addr_sel_e;

  typedef enum logic {
    REG_FLASH_BASE  = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } reg_index_e;

  localparam logic [15:0] CMD_RESET    = 16'h00F0;
  localparam logic [15:0] CMD_UNLOCK_A = 16'h00AA;
  localparam logic [15:0] CMD_UNLOCK_B = 16'h0055;
  localparam logic [15:0] CMD_PROGRAM  = 16'h00A0;
  localparam logic [15:0] CMD_ERASE    = 16'h0080;
  localparam logic [15:0] CMD_SECTOR   = 16'h0030;

  // Word addresses 555 and 2AA, shifted for 16-bit words
  localparam logic [11:0] UNLOCK1_OFF = 12'hAAA;
  localparam logic [11:0] UNLOCK2_OFF = 12'h554;

  localparam logic [7:0] TOGGLE_MASK = 8'h44;  // bits 6 and 2
  localparam logic [7:0] ERROR_MASK  = 8'hA0;  // bits 7 and 5
  localparam logic [7:0] RETRY_RESET = 8'd100;

  localparam int unsigned MaxOps = 8;

  typedef struct packed {
    op_kind_e   kind;
    addr_sel_e  asel;
    logic [15:0] value;
    logic        failed;
  } op_t;

  typedef struct packed {
    op_t [MaxOps-1:0] ops;
    logic [2:0]       last;   // index of the final operation
  } burst_t;

  function automatic op_t mk_op(op_kind_e kind, addr_sel_e asel, logic [15:0] value,
                                logic failed);
    op_t o;
    o.kind   = kind;
    o.asel   = asel;
    o.value  = value;
    o.failed = failed;
    return o;
  endfunction

endpackage

`default_nettype wire

/* rtl/nfcs_decode.sv */
// Command decoder: holds the sequencer state and turns one input transfer
// into a burst of up to eight bus operations. Depends on nfcs_pkg.
`default_nettype none

module nfcs_decode #(
  parameter int unsigned OFFSET_BITS = 21
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire nfcs_pkg::action_e        action_i,
  input  wire logic [OFFSET_BITS-1:0]   offset_i,
  input  wire logic [15:0]              value_i,
  input  wire logic [7:0]               retry_limit_i,
  output nfcs_pkg::burst_t              burst_o,
  output logic                          has_ops_o,
  output logic [OFFSET_BITS-1:0]        target_o
);
  import nfcs_pkg::*;

  phase_e                 phase_q, phase_d;
  logic                   erase_q, erase_d;
  logic [OFFSET_BITS-1:0] target_q, target_d;
  logic [15:0]            pword_q, pword_d;
  logic [7:0]             attempts_q, attempts_d;
  logic [7:0]             status_q, status_d;

  op_t [6:0]   att;
  logic [2:0]  att_last;
  logic        att_erase;
  logic [15:0] att_word;
  logic        new_cmd;
  logic        st_error;
  logic        st_toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      erase_q    <= 1'b0;
      target_q   <= '0;
      pword_q    <= '0;
      attempts_q <= '0;
      status_q   <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      erase_q    <= erase_d;
      target_q   <= target_d;
      pword_q    <= pword_d;
      attempts_q <= attempts_d;
      status_q   <= status_d;
    end
  end

  assign new_cmd   = (action_i == ACT_PROGRAM || action_i == ACT_ERASE) && phase_q == PH_IDLE;
  assign att_erase = new_cmd ? (action_i == ACT_ERASE) : erase_q;
  assign att_word  = new_cmd ? ((action_i == ACT_PROGRAM) ? value_i : 16'h0000) : pword_q;
  assign target_o  = new_cmd ? offset_i : target_q;

  assign st_error  = |(status_q & ERROR_MASK);
  assign st_toggle = |((status_q ^ value_i[7:0]) & TOGGLE_MASK);

  // Unlock and command writes of one attempt, closed by the first status read
  always_comb begin
    att    = '0;
    att[0] = mk_op(OP_WRITE, ASEL_UNLOCK1, CMD_UNLOCK_A, 1'b0);
    att[1] = mk_op(OP_WRITE, ASEL_UNLOCK2, CMD_UNLOCK_B, 1'b0);
    if (att_erase) begin
      att[2]   = mk_op(OP_WRITE, ASEL_UNLOCK1, CMD_ERASE, 1'b0);
      att[3]   = mk_op(OP_WRITE, ASEL_UNLOCK1, CMD_UNLOCK_A, 1'b0);
      att[4]   = mk_op(OP_WRITE, ASEL_UNLOCK2, CMD_UNLOCK_B, 1'b0);
      att[5]   = mk_op(OP_WRITE, ASEL_TARGET, CMD_SECTOR, 1'b0);
      att[6]   = mk_op(OP_READ, ASEL_ZERO, 16'h0000, 1'b0);
      att_last = 3'd6;
    end else begin
      att[2]   = mk_op(OP_WRITE, ASEL_UNLOCK1, CMD_PROGRAM, 1'b0);
      att[3]   = mk_op(OP_WRITE, ASEL_TARGET, att_word, 1'b0);
      att[4]   = mk_op(OP_READ, ASEL_ZERO, 16'h0000, 1'b0);
      att_last = 3'd4;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    erase_d    = erase_q;
    target_d   = target_q;
    pword_d    = pword_q;
    attempts_d = attempts_q;
    status_d   = status_q;
    burst_o    = '0;
    has_ops_o  = 1'b0;
    case (action_i)
      ACT_RESET: begin
        burst_o.ops[0] = mk_op(OP_WRITE, ASEL_ZERO, CMD_RESET, 1'b0);
        burst_o.ops[1] = mk_op(OP_DONE, ASEL_ZERO, 16'h0000, 1'b0);
        burst_o.last   = 3'd1;
        has_ops_o      = 1'b1;
        phase_d        = PH_IDLE;
      end
      ACT_PROGRAM, ACT_ERASE: begin
        if (new_cmd) begin
          erase_d    = att_erase;
          target_d   = offset_i;
          pword_d    = att_word;
          attempts_d = 8'd1;
          phase_d    = PH_FIRST;
          for (int i = 0; i < 7; i++) burst_o.ops[i] = att[i];
          burst_o.last = att_last;
          has_ops_o    = 1'b1;
        end
      end
      ACT_STATUS: begin
        case (phase_q)
          PH_FIRST: begin
            status_d       = value_i[7:0];
            burst_o.ops[0] = mk_op(OP_READ, ASEL_ZERO, 16'h0000, 1'b0);
            burst_o.last   = 3'd0;
            has_ops_o      = 1'b1;
            phase_d        = PH_SECOND;
          end
          PH_SECOND: begin
            has_ops_o = 1'b1;
            if (st_error) begin
              burst_o.ops[0] = mk_op(OP_WRITE, ASEL_ZERO, CMD_RESET, 1'b0);
              if (attempts_q < retry_limit_i) begin
                // Reset the device, then replay the whole attempt
                for (int i = 1; i < MaxOps; i++) burst_o.ops[i] = att[i-1];
                burst_o.last = att_last + 3'd1;
                attempts_d   = attempts_q + 8'd1;
                phase_d      = PH_FIRST;
              end else begin
                burst_o.ops[1] = mk_op(OP_DONE, ASEL_ZERO, 16'h0000, 1'b1);
                burst_o.last   = 3'd1;
                phase_d        = PH_IDLE;
              end
            end else if (!st_toggle) begin
              if (erase_q) begin
                burst_o.ops[0] = mk_op(OP_WRITE, ASEL_ZERO, CMD_RESET, 1'b0);
                burst_o.ops[1] = mk_op(OP_DONE, ASEL_ZERO, 16'h0000, 1'b0);
                burst_o.last   = 3'd1;
              end else begin
                burst_o.ops[0] = mk_op(OP_DONE, ASEL_ZERO, 16'h0000, 1'b0);
                burst_o.last   = 3'd0;
              end
              phase_d = PH_IDLE;
            end else begin
              burst_o.ops[0] = mk_op(OP_READ, ASEL_ZERO, 16'h0000, 1'b0);
              burst_o.last   = 3'd0;
              phase_d        = PH_FIRST;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nfcs_emit.sv */
// Result stage: holds one decoded burst and hands its bus operations out one
// transfer at a time, forming the absolute address. Depends on nfcs_pkg.
`default_nettype none

module nfcs_emit #(
  parameter int unsigned OFFSET_BITS = 21
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire nfcs_pkg::burst_t       burst_i,
  input  wire logic [OFFSET_BITS-1:0] target_i,
  input  wire logic [31:0]            flash_base_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_last_o,
  output logic                        free_o,
  output nfcs_pkg::op_kind_e          op_kind_o,
  output logic [31:0]                 bus_address_o,
  output logic [15:0]                 bus_value_o,
  output logic                        failed_o
);
  import nfcs_pkg::*;

  logic                   busy_q, busy_d;
  burst_t                 burst_q;
  logic [2:0]             idx_q, idx_d;
  logic [OFFSET_BITS-1:0] target_q;
  op_t                    cur;
  logic [31:0]            off;
  logic                   take;

  assign take        = busy_q && out_ready_i;
  assign out_valid_o = busy_q;
  assign out_last_o  = idx_q == burst_q.last;
  assign free_o      = !busy_q || (take && out_last_o);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = 3'd0;
    end else if (take && out_last_o) begin
      busy_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Burst payload, held until the next load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q  <= burst_i;
      target_q <= target_i;
    end
  end

  assign cur = burst_q.ops[idx_q];

  always_comb begin
    case (cur.asel)
      ASEL_ZERO:    off = '0;
      ASEL_UNLOCK1: off = 32'(UNLOCK1_OFF);
      ASEL_UNLOCK2: off = 32'(UNLOCK2_OFF);
      ASEL_TARGET:  off = 32'(target_q);
      default:      off = '0;
    endcase
  end

  assign op_kind_o     = cur.kind;
  assign bus_address_o = (cur.kind == OP_DONE) ? 32'h0 : flash_base_i + off;
  assign bus_value_o   = cur.value;
  assign failed_o      = cur.failed;

endmodule

`default_nettype wire

/* rtl/nor_flash_command_sequencer_unit.sv */
// Timing: the first bus operation of a command is shown the cycle after its
// input transfer; a burst drains one operation per accepted output transfer.
// Throughput: one input per burst, as the burst holding register sets it;
// single-op bursts (status polls) take one input per cycle if not stalled.
// Reset: asynchronous, active low; idle phase, base 0, retry limit 100.
`default_nettype none

module nor_flash_command_sequencer_unit #(
  parameter int unsigned OFFSET_BITS = 21
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Commands and status read data
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // offset [OFFSET_BITS-1:0], value [OFFSET_BITS+15:OFFSET_BITS], zero pad
  input  wire logic [8*((OFFSET_BITS+16+7)/8)-1:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,     // action
  // Bus operations
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bus_address [31:0], bus_value [47:32], failed [48], zero pad [55:49]
  output logic [55:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,     // op_kind
  output logic             m_axis_tlast      // last_of_run
);
  import nfcs_pkg::*;

  logic [31:0] flash_base_q;
  logic [7:0]  retry_limit_q;
  logic        accept;
  logic        free;
  burst_t      burst;
  logic        has_ops;
  logic [OFFSET_BITS-1:0] target;
  op_kind_e    op_kind;
  logic [31:0] bus_address;
  logic [15:0] bus_value;
  logic        failed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q  <= '0;
      retry_limit_q <= RETRY_RESET;
    end else if (cfg_valid_i && cfg_index_i[7:1] == 7'd0) begin
      case (reg_index_e'(cfg_index_i[0]))
        REG_FLASH_BASE:  flash_base_q  <= cfg_data_i;
        REG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  nfcs_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action_e'(s_axis_tuser)),
    .offset_i      (s_axis_tdata[OFFSET_BITS-1:0]),
    .value_i       (s_axis_tdata[OFFSET_BITS+15:OFFSET_BITS]),
    .retry_limit_i (retry_limit_q),
    .burst_o       (burst),
    .has_ops_o     (has_ops),
    .target_o      (target)
  );

  nfcs_emit #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && has_ops),
    .burst_i       (burst),
    .target_i      (target),
    .flash_base_i  (flash_base_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_last_o    (m_axis_tlast),
    .free_o        (free),
    .op_kind_o     (op_kind),
    .bus_address_o (bus_address),
    .bus_value_o   (bus_value),
    .failed_o      (failed)
  );

  assign m_axis_tuser = op_kind;
  assign m_axis_tdata = {7'd0, failed, bus_value, bus_address};

endmodule

`default_nettype wire
